FILE: src/pso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pso_pkg;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INERTIA   = 2'd0;
  localparam cfg_idx_t CFG_COGNITIVE = 2'd1;
  localparam cfg_idx_t CFG_SOCIAL    = 2'd2;

  localparam logic [15:0] INERTIA_RST   = 16'd4096;
  localparam logic [15:0] COGNITIVE_RST = 16'd8192;
  localparam logic [15:0] SOCIAL_RST    = 16'd8192;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] pbest_value;
    logic signed [31:0] lbest_value;
    logic        [15:0] rand_pbest;
    logic        [15:0] rand_lbest;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic               last_dim;
  } pso_in_t;

  typedef struct packed {
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_position;
    logic               was_clamped;
    logic               saturated;
    logic        [31:0] speed_out;
    logic               last_out;
  } pso_out_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [15:0] wdata;
  } pso_cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LD_K1,
    OP_LD_K2,
    OP_ACC_SET,
    OP_ACC_ADD,
    OP_SAT_V,
    OP_POS,
    OP_CLAMP,
    OP_ABS,
    OP_ACCUM,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    MS_C1R1,
    MS_C2R2,
    MS_WV,
    MS_K1D1,
    MS_K2D2,
    MS_MAG
  } mul_sel_e;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_NO_IN,
    JMP_NOT_LAST,
    JMP_SQRT_MORE,
    JMP_OUT_BUSY
  } jmp_e;

  typedef struct packed {
    op_e      op;
    logic     mul_en;
    mul_sel_e mul_sel;
    jmp_e     jmp;
    step_t    target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic last;
    logic sqrt_more;
  } status_t;

  localparam step_t ST_CAPTURE = 4'd0;
  localparam step_t ST_ACCUM   = 4'd12;
  localparam step_t ST_SQRT    = 4'd14;
  localparam step_t ST_OUT     = 4'd15;

  function automatic ctrl_t mk(op_e op, logic en, mul_sel_e sel, jmp_e jmp, step_t tgt);
    ctrl_t c;
    c.op      = op;
    c.mul_en  = en;
    c.mul_sel = sel;
    c.jmp     = jmp;
    c.target  = tgt;
    return c;
  endfunction

  // microprogram; the step after ST_OUT wraps to ST_CAPTURE
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      4'd0:    c = mk(OP_CAPTURE,   1'b0, MS_C1R1, JMP_NO_IN,     ST_CAPTURE);
      4'd1:    c = mk(OP_NOP,       1'b1, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd2:    c = mk(OP_LD_K1,     1'b1, MS_C2R2, JMP_NONE,      ST_CAPTURE);
      4'd3:    c = mk(OP_LD_K2,     1'b1, MS_WV,   JMP_NONE,      ST_CAPTURE);
      4'd4:    c = mk(OP_ACC_SET,   1'b1, MS_K1D1, JMP_NONE,      ST_CAPTURE);
      4'd5:    c = mk(OP_ACC_ADD,   1'b1, MS_K2D2, JMP_NONE,      ST_CAPTURE);
      4'd6:    c = mk(OP_ACC_ADD,   1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd7:    c = mk(OP_SAT_V,     1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd8:    c = mk(OP_POS,       1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd9:    c = mk(OP_CLAMP,     1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd10:   c = mk(OP_ABS,       1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd11:   c = mk(OP_NOP,       1'b1, MS_MAG,  JMP_NONE,      ST_CAPTURE);
      4'd12:   c = mk(OP_ACCUM,     1'b0, MS_C1R1, JMP_NOT_LAST,  ST_OUT);
      4'd13:   c = mk(OP_SQRT_INIT, 1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
      4'd14:   c = mk(OP_SQRT,      1'b0, MS_C1R1, JMP_SQRT_MORE, ST_SQRT);
      4'd15:   c = mk(OP_OUT,       1'b0, MS_C1R1, JMP_OUT_BUSY,  ST_OUT);
      default: c = mk(OP_NOP,       1'b0, MS_C1R1, JMP_NONE,      ST_CAPTURE);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/pso_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pso_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/pso_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module pso_seq
  import pso_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_t step_q, step_d;
  logic  take;

  assign ctrl_o = ucode(step_q);

  always_comb begin
    unique case (ctrl_o.jmp)
      JMP_NONE:      take = 1'b0;
      JMP_NO_IN:     take = !status_i.in_valid;
      JMP_NOT_LAST:  take = !status_i.last;
      JMP_SQRT_MORE: take = status_i.sqrt_more;
      JMP_OUT_BUSY:  take = status_i.out_busy;
      default:       take = 1'b0;
    endcase
    step_d = take ? ctrl_o.target : step_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_CAPTURE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/pso_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pso_mul (
  input  wire                clk_i,
  input  wire                en_i,
  input  wire signed  [32:0] a_i,
  input  wire signed  [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/pso_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pso_dp
  import pso_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 64
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  ctrl_t   ctrl_i,
  output status_t status_o,
  pso_stream_if.sink   in_s,
  pso_stream_if.sink   cfg_s,
  pso_stream_if.source out_s
);

  localparam int unsigned CntW = $clog2(MAX_DIMS + 1);
  localparam logic [CntW:0] MaxDims = (CntW + 1)'(MAX_DIMS);

  logic [15:0] w_q, c1_q, c2_q;

  logic signed [31:0] x_q, v_q, lo_q, hi_q;
  logic signed [32:0] d1_q, d2_q;
  logic [15:0] r1_q, r2_q, k1_q, k2_q;
  logic last_q, sat_q, clamped_q;
  logic signed [39:0] acc_q;
  logic signed [31:0] nv_q, np_q;
  logic signed [32:0] mag_q;

  logic [63:0] accum_q;
  logic [CntW-1:0] dim_cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  sq_cnt_q;

  logic     out_valid_q;
  pso_out_t out_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] prod_sh;
  logic signed [39:0] term;
  logic signed [32:0] pos_sum;
  logic [64:0] accum_sum;
  logic [CntW:0] dim_inc;
  logic last_eff;
  logic [35:0] sq_shift, sq_trial;
  logic out_busy;

  always_comb begin
    unique case (ctrl_i.mul_sel)
      MS_C1R1: begin
        mul_a = {17'b0, c1_q};
        mul_b = {17'b0, r1_q};
      end
      MS_C2R2: begin
        mul_a = {17'b0, c2_q};
        mul_b = {17'b0, r2_q};
      end
      MS_WV: begin
        mul_a = {v_q[31], v_q};
        mul_b = {17'b0, w_q};
      end
      MS_K1D1: begin
        mul_a = d1_q;
        mul_b = {17'b0, k1_q};
      end
      MS_K2D2: begin
        mul_a = d2_q;
        mul_b = {17'b0, k2_q};
      end
      MS_MAG: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pso_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl_i.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign prod_sh   = prod >>> 12;
  assign term      = prod_sh[39:0];
  assign pos_sum   = {x_q[31], x_q} + {nv_q[31], nv_q};
  assign accum_sum = {1'b0, accum_q} + {1'b0, prod[63:0]};
  assign dim_inc   = {1'b0, dim_cnt_q} + {{CntW{1'b0}}, 1'b1};
  assign last_eff  = last_q | (dim_inc >= MaxDims);
  assign sq_shift  = {rem_q, rad_q[63:62]};
  assign sq_trial  = {2'b00, root_q, 2'b01};
  assign out_busy  = out_valid_q & !out_s.ready;

  assign in_s.ready  = (ctrl_i.op == OP_CAPTURE);
  assign cfg_s.ready = 1'b1;
  assign out_s.valid   = out_valid_q;
  assign out_s.payload = out_q;

  assign status_o.in_valid  = in_s.valid;
  assign status_o.out_busy  = out_busy;
  assign status_o.last      = last_eff;
  assign status_o.sqrt_more = (sq_cnt_q != 5'd31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= INERTIA_RST;
      c1_q        <= COGNITIVE_RST;
      c2_q        <= SOCIAL_RST;
      accum_q     <= '0;
      dim_cnt_q   <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_s.valid) begin
        unique case (cfg_s.payload.index)
          CFG_INERTIA:   w_q  <= cfg_s.payload.wdata;
          CFG_COGNITIVE: c1_q <= cfg_s.payload.wdata;
          CFG_SOCIAL:    c2_q <= cfg_s.payload.wdata;
          default: ;
        endcase
      end

      priority if (ctrl_i.op == OP_OUT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_s.ready) begin
        out_valid_q <= 1'b0;
      end else begin
      end

      unique case (ctrl_i.op)
        OP_ACCUM: begin
          accum_q   <= accum_sum[64] ? '1 : accum_sum[63:0];
          dim_cnt_q <= last_eff ? '0 : dim_inc[CntW-1:0];
        end
        OP_SQRT_INIT: begin
          accum_q  <= '0;
          sq_cnt_q <= '0;
        end
        OP_SQRT: begin
          sq_cnt_q <= sq_cnt_q + 5'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_CAPTURE: begin
        if (in_s.valid) begin
          x_q       <= in_s.payload.position;
          v_q       <= in_s.payload.velocity;
          d1_q      <= {in_s.payload.pbest_value[31], in_s.payload.pbest_value}
                     - {in_s.payload.position[31], in_s.payload.position};
          d2_q      <= {in_s.payload.lbest_value[31], in_s.payload.lbest_value}
                     - {in_s.payload.position[31], in_s.payload.position};
          r1_q      <= in_s.payload.rand_pbest;
          r2_q      <= in_s.payload.rand_lbest;
          lo_q      <= in_s.payload.range_low;
          hi_q      <= in_s.payload.range_high;
          last_q    <= in_s.payload.last_dim;
          sat_q     <= 1'b0;
          clamped_q <= 1'b0;
        end
      end
      OP_LD_K1:   k1_q  <= prod[31:16];
      OP_LD_K2:   k2_q  <= prod[31:16];
      OP_ACC_SET: acc_q <= term;
      OP_ACC_ADD: acc_q <= acc_q + term;
      OP_SAT_V: begin
        if (acc_q[39:31] != {9{acc_q[39]}}) begin
          nv_q  <= acc_q[39] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          sat_q <= 1'b1;
        end else begin
          nv_q <= acc_q[31:0];
        end
      end
      OP_POS: begin
        if (pos_sum[32] != pos_sum[31]) begin
          np_q  <= pos_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          sat_q <= 1'b1;
        end else begin
          np_q <= pos_sum[31:0];
        end
      end
      OP_CLAMP: begin
        priority if (np_q > hi_q) begin
          np_q      <= hi_q;
          nv_q      <= '0;
          clamped_q <= 1'b1;
        end else if (np_q < lo_q) begin
          np_q      <= lo_q;
          nv_q      <= '0;
          clamped_q <= 1'b1;
        end else begin
        end
      end
      OP_ABS: mag_q <= nv_q[31] ? -{nv_q[31], nv_q} : {nv_q[31], nv_q};
      OP_ACCUM: begin
        last_q <= last_eff;
        if (accum_sum[64]) begin
          sat_q <= 1'b1;
        end
      end
      OP_SQRT_INIT: begin
        rad_q  <= accum_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQRT: begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (sq_shift >= sq_trial) begin
          rem_q  <= 34'(sq_shift - sq_trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= sq_shift[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_q.new_velocity <= nv_q;
          out_q.new_position <= np_q;
          out_q.was_clamped  <= clamped_q;
          out_q.saturated    <= sat_q;
          out_q.speed_out    <= last_q ? root_q : '0;
          out_q.last_out     <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/pso_particle_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  payload    transfer
// in_i     in   pso_in_t   one particle dimension
// cfg_i    in   pso_cfg_t  register write: w, c1, c2
// out_o    out  pso_out_t  one result per dimension
//
// A result follows its input transfer through the microprogram steps; on a particle's
// last dimension the 32-step square root runs first. The next input is taken after
// the output step. The microprogram shares its single multiplier across its steps.
// Reset restores the coefficients and clears the square sum and dimension count.
// A result waits in the output register; the next dimension is computed meanwhile
// and holds in its final step until that register is free.

module pso_particle_update_unit
  import pso_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 64
) (
  input wire clk_i,
  input wire rst_ni,
  pso_stream_if.sink   in_i,
  pso_stream_if.sink   cfg_i,
  pso_stream_if.source out_o
);

  ctrl_t   ctrl;
  status_t status;

  pso_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  pso_dp #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .in_s     (in_i),
    .cfg_s    (cfg_i),
    .out_s    (out_o)
  );

endmodule

`default_nettype wire
